>>> sv/yuv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// Types and constants shared by the packed 4:2:2 to RGB888 converter.
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

    typedef enum logic [1:0] {
        ORDER_YUYV = 2'd0,
        ORDER_YVYU = 2'd1,
        ORDER_UYVY = 2'd2
    } byte_order_t;

    typedef logic [1:0] byte_order_raw_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } macropixel_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } rgb_pair_t;

    // unpacked macropixel, chroma already recentered
    typedef struct packed {
        logic        [7:0] y0;
        logic        [7:0] y1;
        logic signed [8:0] u;
        logic signed [8:0] v;
    } yuv_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam int          ACC_W       = 18;
    localparam logic [7:0]  CHROMA_BIAS = 8'd128;

    localparam logic signed [ACC_W-1:0] COEF_RV = 18'sd359;
    localparam logic signed [ACC_W-1:0] COEF_GU = 18'sd88;
    localparam logic signed [ACC_W-1:0] COEF_GV = 18'sd183;
    localparam logic signed [ACC_W-1:0] COEF_BU = 18'sd454;

    // floor(x / 256) then saturate to 0..255
    function automatic logic [7:0] shift_clamp8(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-9:0] q;
        logic [7:0]              res;
        q = x[ACC_W-1:8];
        if (q < 0)
        begin
            res = 8'd0;
        end
        else if (q > 255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

>>> sv/yuv2rgb_stream_if.sv
// ----------------------------------------------------------------------------
// yuv2rgb_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface yuv2rgb_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/yuv2rgb_unpack.sv
// ----------------------------------------------------------------------------
// yuv2rgb_unpack
// Picks lumas and chromas out of a macropixel and recenters the chroma.
// ----------------------------------------------------------------------------
module yuv2rgb_unpack
    import yuv2rgb_pkg::*;
(
    input  macropixel_t     mp,
    input  byte_order_raw_t byte_order,
    output yuv_t            yuv
);

    logic [7:0] u_raw;
    logic [7:0] v_raw;

    always_comb
    begin
        unique case (byte_order)
            ORDER_YVYU:
            begin
                yuv.y0 = mp.byte0;
                v_raw  = mp.byte1;
                yuv.y1 = mp.byte2;
                u_raw  = mp.byte3;
            end
            ORDER_UYVY:
            begin
                u_raw  = mp.byte0;
                yuv.y0 = mp.byte1;
                v_raw  = mp.byte2;
                yuv.y1 = mp.byte3;
            end
            default:
            begin
                // YUYV, and the unused code decodes the same way
                yuv.y0 = mp.byte0;
                u_raw  = mp.byte1;
                yuv.y1 = mp.byte2;
                v_raw  = mp.byte3;
            end
        endcase
        yuv.u = $signed({1'b0, u_raw}) - $signed({1'b0, CHROMA_BIAS});
        yuv.v = $signed({1'b0, v_raw}) - $signed({1'b0, CHROMA_BIAS});
    end

endmodule

>>> sv/yuv2rgb_lane.sv
// ----------------------------------------------------------------------------
// yuv2rgb_lane
// One pixel converter: registered chroma products, then sum, shift, clamp.
// ----------------------------------------------------------------------------
module yuv2rgb_lane
    import yuv2rgb_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        y,
    input  logic signed [8:0] u,
    input  logic signed [8:0] v,
    output rgb_t              rgb
);

    logic signed [ACC_W-1:0] u_ext;
    logic signed [ACC_W-1:0] v_ext;
    logic signed [ACC_W-1:0] r_term_next, g_term_next, b_term_next;
    logic signed [ACC_W-1:0] r_term_reg,  g_term_reg,  b_term_reg;
    logic [7:0]              y_reg;
    logic signed [ACC_W-1:0] y_scaled;

    assign u_ext = ACC_W'(u);
    assign v_ext = ACC_W'(v);

    always_comb
    begin
        r_term_next = COEF_RV * v_ext;
        g_term_next = (COEF_GU * u_ext) + (COEF_GV * v_ext);
        b_term_next = COEF_BU * u_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg      <= y;
            r_term_reg <= r_term_next;
            g_term_reg <= g_term_next;
            b_term_reg <= b_term_next;
        end
    end

    assign y_scaled = $signed({2'b00, y_reg, 8'd0});

    always_comb
    begin
        rgb.red   = shift_clamp8(y_scaled + r_term_reg);
        rgb.green = shift_clamp8(y_scaled - g_term_reg);
        rgb.blue  = shift_clamp8(y_scaled + b_term_reg);
    end

endmodule

>>> sv/packed_yuv422_to_rgb.sv
// ----------------------------------------------------------------------------
// packed_yuv422_to_rgb
// Packed 4:2:2 macropixel to two RGB888 pixels.
// ----------------------------------------------------------------------------
// Takes one macropixel request per clock and returns one pixel pair per
// clock while pixels.ready holds, through three registered stages: an
// unpack register, a register of chroma products in each of the two pixel
// lanes, and the output register that merges both lanes. Every stage moves
// on whenever its successor is empty or moving, so bubbles close up and a
// waiting result does not stop new requests until all three stages are
// full. byte_order (0 YUYV, 1 YVYU, 2 UYVY, 3 as YUYV) is written through
// cfg, which is always ready; change it only while the pipeline is empty.
module packed_yuv422_to_rgb
    import yuv2rgb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    yuv2rgb_stream_if.sink   macropixel,
    yuv2rgb_stream_if.sink   cfg,
    yuv2rgb_stream_if.source pixels
);

    byte_order_raw_t byte_order_reg;
    yuv_t            yuv_next, yuv_reg;
    rgb_t            rgb_first, rgb_second;
    rgb_pair_t       out_next, out_reg;
    logic            v1_reg, v2_reg, v3_reg;
    logic            en1, en2, en3;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_order_reg <= ORDER_YUYV;
        end
        else if (cfg.valid)
        begin
            byte_order_reg <= cfg.data;
        end
    end

    assign en3 = !v3_reg || pixels.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign macropixel.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= macropixel.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    yuv2rgb_unpack u_unpack (
        .mp         (macropixel.data),
        .byte_order (byte_order_reg),
        .yuv        (yuv_next)
    );

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            yuv_reg <= yuv_next;
        end
    end

    yuv2rgb_lane u_lane_first (
        .clk (clk),
        .en  (en2),
        .y   (yuv_reg.y0),
        .u   (yuv_reg.u),
        .v   (yuv_reg.v),
        .rgb (rgb_first)
    );

    yuv2rgb_lane u_lane_second (
        .clk (clk),
        .en  (en2),
        .y   (yuv_reg.y1),
        .u   (yuv_reg.u),
        .v   (yuv_reg.v),
        .rgb (rgb_second)
    );

    // merge both lanes into the output word
    always_comb
    begin
        out_next.red_first    = rgb_first.red;
        out_next.green_first  = rgb_first.green;
        out_next.blue_first   = rgb_first.blue;
        out_next.red_second   = rgb_second.red;
        out_next.green_second = rgb_second.green;
        out_next.blue_second  = rgb_second.blue;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            out_reg <= out_next;
        end
    end

    assign pixels.valid = v3_reg;
    assign pixels.data  = out_reg;

    // input only backs up when every stage holds a request
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !macropixel.ready |-> (v1_reg && v2_reg && v3_reg && !pixels.ready)
    ) else $error("input stalled with room in the pipeline");

    // a result only appears from the stage before or stays from last cycle
    a_output_origin: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg)
    ) else $error("output valid without a request in the lane stage");

    // an accepted request always lands in the first stage
    a_accept_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (macropixel.valid && macropixel.ready) |=> v1_reg
    ) else $error("accepted request lost at the unpack stage");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packed 4:2:2 to RGB888 converter: edge-value
// macropixels under every layout code, then random macropixels across
// several layouts with random gaps on both sides, a long output hold-off
// and a full drain pause. Results are predicted per request and compared
// field by field in order.
// ----------------------------------------------------------------------------
import yuv2rgb_pkg::*;

class pixel_pair_scoreboard;
    byte_order_raw_t order;
    rgb_pair_t       expected_q[$];
    int              mismatches;

    function new();
        order      = ORDER_YUYV;
        mismatches = 0;
    endfunction

    function void set_order(byte_order_raw_t code);
        order = code;
    endfunction

    function logic [7:0] saturate(int x);
        if (x < 0)
        begin
            return 8'd0;
        end
        if (x > 255)
        begin
            return 8'd255;
        end
        return x[7:0];
    endfunction

    // >>> on a signed int floors, matching the block's arithmetic shift
    function rgb_t to_rgb(int luma, int cb, int cr);
        rgb_t px;
        int   ys;
        ys       = luma * 256;
        px.red   = saturate((ys + int'(COEF_RV) * cr) >>> 8);
        px.green = saturate((ys - int'(COEF_GU) * cb - int'(COEF_GV) * cr) >>> 8);
        px.blue  = saturate((ys + int'(COEF_BU) * cb) >>> 8);
        return px;
    endfunction

    function void note_macropixel(macropixel_t mp);
        int        y0;
        int        y1;
        int        cb;
        int        cr;
        rgb_t      first_px;
        rgb_t      second_px;
        rgb_pair_t want;
        case (order)
            ORDER_YVYU:
            begin
                y0 = mp.byte0; cr = mp.byte1; y1 = mp.byte2; cb = mp.byte3;
            end
            ORDER_UYVY:
            begin
                cb = mp.byte0; y0 = mp.byte1; cr = mp.byte2; y1 = mp.byte3;
            end
            default:
            begin
                // code 3 decodes as YUYV
                y0 = mp.byte0; cb = mp.byte1; y1 = mp.byte2; cr = mp.byte3;
            end
        endcase
        cb = cb - int'(CHROMA_BIAS);
        cr = cr - int'(CHROMA_BIAS);
        first_px           = to_rgb(y0, cb, cr);
        second_px          = to_rgb(y1, cb, cr);
        want.red_first     = first_px.red;
        want.green_first   = first_px.green;
        want.blue_first    = first_px.blue;
        want.red_second    = second_px.red;
        want.green_second  = second_px.green;
        want.blue_second   = second_px.blue;
        expected_q.push_back(want);
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch: %s expected %h got %h", what, want, got);
        end
    endfunction

    function void check_pair(rgb_pair_t got);
        rgb_pair_t  want;
        logic [7:0] want_f[6];
        logic [7:0] got_f[6];
        string      field_name[6];
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch: unexpected pixel pair %h", got);
            end
            return;
        end
        want       = expected_q.pop_front();
        field_name = '{"red_first", "green_first", "blue_first",
                       "red_second", "green_second", "blue_second"};
        want_f     = '{want.red_first, want.green_first, want.blue_first,
                       want.red_second, want.green_second, want.blue_second};
        got_f      = '{got.red_first, got.green_first, got.blue_first,
                       got.red_second, got.green_second, got.blue_second};
        for (int i = 0; i < 6; i++)
        begin
            if (got_f[i] !== want_f[i])
            begin
                flag(field_name[i], want_f[i], got_f[i]);
            end
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction

    function bit clean();
        return (mismatches == 0) && (expected_q.size() == 0);
    endfunction
endclass

module tb_top;

    localparam byte_order_raw_t ORDER_ALIAS_YUYV = 2'd3;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 113;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    int   tx_gap_max;
    int   rx_gap_max;
    bit   hold_off_req;

    yuv2rgb_stream_if #(.payload_t(macropixel_t))     macropixel ();
    yuv2rgb_stream_if #(.payload_t(byte_order_raw_t)) cfg ();
    yuv2rgb_stream_if #(.payload_t(rgb_pair_t))       pixels ();

    pixel_pair_scoreboard sb = new();

    byte_order_raw_t directed_orders[4] = '{ORDER_YUYV, ORDER_YVYU, ORDER_UYVY,
                                            ORDER_ALIAS_YUYV};
    byte_order_raw_t random_orders[RANDOM_PHASES] = '{ORDER_UYVY, ORDER_YVYU,
                                                      ORDER_ALIAS_YUYV, ORDER_YUYV,
                                                      ORDER_UYVY, ORDER_YVYU};
    macropixel_t edge_patterns[6] = '{32'h00000000, 32'hFFFFFFFF, 32'h80808080,
                                      32'h00FF00FF, 32'hFF00FF00, 32'h01FEFE01};

    packed_yuv422_to_rgb dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .macropixel (macropixel),
        .cfg        (cfg),
        .pixels     (pixels)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // monitors: sampled at the edge, before any update of this step lands
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (cfg.valid && cfg.ready)
            begin
                sb.set_order(cfg.data);
            end
            if (macropixel.valid && macropixel.ready)
            begin
                sb.note_macropixel(macropixel.data);
            end
            if (pixels.valid && pixels.ready)
            begin
                sb.check_pair(pixels.data);
            end
        end
    end

    // output side: random gap per result, one long hold-off on request
    initial
    begin : sink_side
        int gap;
        pixels.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = $urandom_range(0, rx_gap_max);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap          = HOLD_OFF_CYCLES;
            end
            if (gap > 0)
            begin
                pixels.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pixels.ready <= 1'b1;
            @(posedge clk);
            while (!pixels.valid)
            begin
                @(posedge clk);
            end
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CHROMA_BIAS;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_macropixel(input macropixel_t mp);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            macropixel.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        macropixel.valid <= 1'b1;
        macropixel.data  <= mp;
        @(posedge clk);
        while (!macropixel.ready)
        begin
            @(posedge clk);
        end
    endtask

    // drop valid and let the monitor log the last accepted request before polling
    task automatic wait_for_results();
        macropixel.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_order(input byte_order_raw_t code);
        cfg.valid <= 1'b1;
        cfg.data  <= code;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        macropixel_t mp;
        macropixel.valid = 1'b0;
        macropixel.data  = '0;
        cfg.valid        = 1'b0;
        cfg.data         = '0;
        rst_n            = 1'b0;
        hold_off_req     = 1'b0;
        tx_gap_max       = 3;
        rx_gap_max       = 3;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 4; p++)
        begin
            write_order(directed_orders[p]);
            for (int i = 0; i < 6; i++)
            begin
                send_macropixel(edge_patterns[i]);
            end
            wait_for_results();
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            tx_gap_max = (p % 3 == 1) ? 0 : 9;
            rx_gap_max = (p % 2 == 0) ? 9 : 0;
            write_order(random_orders[p]);
            // back-to-back requests against a stalled output
            if (p == 1)
            begin
                hold_off_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == PHASE_ITEMS / 2)
                begin
                    wait_for_results();
                end
                mp.byte0 = pick_byte();
                mp.byte1 = pick_byte();
                mp.byte2 = pick_byte();
                mp.byte3 = pick_byte();
                send_macropixel(mp);
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.clean())
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/yuv2rgb_pkg.sv
sv/yuv2rgb_stream_if.sv
sv/yuv2rgb_unpack.sv
sv/yuv2rgb_lane.sv
sv/packed_yuv422_to_rgb.sv
tb/tb_top.sv
